// ===== rtl/rgbbl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the RGB565 blend blitter.
// No dependencies; every other file refers to it by scoped names.
package rgbbl_pkg;

   // Pixel operation codes carried in req_tuser
   typedef enum logic [2:0] {
      OP_COV8  = 3'd0,
      OP_COV4  = 3'd1,
      OP_COPY  = 3'd2,
      OP_KEY   = 3'd3,
      OP_BLEND = 3'd4
   } op_type;

   // Control register indexes
   typedef enum logic [1:0] {
      CSR_TINT_RED   = 2'd0,
      CSR_TINT_GREEN = 2'd1,
      CSR_TINT_BLUE  = 2'd2,
      CSR_ROWS       = 2'd3
   } csr_idx_type;

   localparam int CSR_WIDTH  = 12;
   localparam logic [11:0] ROWS_RESET = 12'd240;
   localparam logic [7:0]  ALPHA_MAX  = 8'd255;

   typedef struct packed {
      logic [7:0]  tint_red;
      logic [7:0]  tint_green;
      logic [7:0]  tint_blue;
      logic [11:0] screen_rows;
   } cfg_type;

   // Decode stage word
   typedef struct packed {
      logic        blend;
      logic        we;
      logic [15:0] pix;
      logic [15:0] col;
      logic [7:0]  alpha;
      logic [15:0] dst;
   } dec_type;

   // Multiply stage word
   typedef struct packed {
      logic        blend;
      logic        we;
      logic [15:0] pix;
      logic [12:0] r_src;
      logic [13:0] g_src;
      logic [12:0] b_src;
      logic [12:0] r_dst;
      logic [13:0] g_dst;
      logic [12:0] b_dst;
   } mul_type;

   // Pack 8-bit components into RGB565
   function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

   // floor(p / 255) for p below 16320, by reciprocal with correction
   function automatic logic [5:0] div255(input logic [13:0] p);
      logic [14:0] t;
      t = {1'b0, p} + 15'd1 + {9'd0, p[13:8]};
      return t[13:8];
   endfunction

endpackage

// ===== rtl/rgbbl_decode.sv =====
`timescale 1ns / 1ps
// First pipeline stage: row clip, mode decode, alpha and colour selection.
// Uses rgbbl_pkg types and functions.
module rgbbl_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  logic [2:0]           opcode,
   input  logic                 nibble_select,
   input  logic [31:0]          source_word,
   input  logic [15:0]          dest_pixel,
   input  logic [15:0]          dest_row,
   input  rgbbl_pkg::cfg_type   cfg,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output rgbbl_pkg::dec_type   dn_word
);

   logic                v_ff;
   rgbbl_pkg::dec_type  word_ff;
   rgbbl_pkg::dec_type  word_in;
   logic                row_ok;
   logic [7:0]          b0, b1, b2, b3;
   logic [7:0]          cov_alpha;
   logic [15:0]         src_col;
   logic [15:0]         tint_col;

   assign b0 = source_word[7:0];
   assign b1 = source_word[15:8];
   assign b2 = source_word[23:16];
   assign b3 = source_word[31:24];

   // Clip negative rows and rows at or beyond the screen height
   assign row_ok = !dest_row[15] && (dest_row[14:0] < {3'd0, cfg.screen_rows});

   assign src_col  = rgbbl_pkg::pack565(b0, b1, b2);
   assign tint_col = rgbbl_pkg::pack565(cfg.tint_red, cfg.tint_green, cfg.tint_blue);

   // Coverage alpha: full byte, or one nibble moved to the high half
   always_comb begin
      if (rgbbl_pkg::op_type'(opcode) == rgbbl_pkg::OP_COV8) begin
         cov_alpha = b0;
      end else if (nibble_select) begin
         cov_alpha = {b0[3:0], 4'h0};
      end else begin
         cov_alpha = {b0[7:4], 4'h0};
      end
   end

   // Decide write, blend and direct pixel
   always_comb begin
      word_in.blend = 1'b0;
      word_in.we    = 1'b0;
      word_in.pix   = dest_pixel;
      word_in.col   = tint_col;
      word_in.alpha = cov_alpha;
      word_in.dst   = dest_pixel;
      if (row_ok) begin
         case (rgbbl_pkg::op_type'(opcode))
            rgbbl_pkg::OP_COV8, rgbbl_pkg::OP_COV4: begin
               if (cov_alpha != 8'd0) begin
                  word_in.blend = 1'b1;
                  word_in.we    = 1'b1;
               end
            end
            rgbbl_pkg::OP_COPY: begin
               word_in.pix = source_word[15:0];
               word_in.we  = 1'b1;
            end
            rgbbl_pkg::OP_KEY: begin
               if (src_col != 16'd0) begin
                  word_in.pix = src_col;
                  word_in.we  = 1'b1;
               end
            end
            rgbbl_pkg::OP_BLEND: begin
               word_in.col   = src_col;
               word_in.alpha = b3;
               word_in.blend = 1'b1;
               word_in.we    = 1'b1;
            end
            default: begin
               word_in.we = 1'b0;
            end
         endcase
      end
   end

   assign up_ready = !v_ff || dn_ready;

   // Advance the stage whenever its slot is free or drains
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (up_ready) begin
         v_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         word_ff <= word_in;
      end
   end

   assign dn_valid = v_ff;
   assign dn_word  = word_ff;

endmodule

// ===== rtl/rgbbl_mul.sv =====
`timescale 1ns / 1ps
// Second pipeline stage: per-field products with alpha and 255 - alpha.
// Uses rgbbl_pkg types.
module rgbbl_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  rgbbl_pkg::dec_type   up_word,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output rgbbl_pkg::mul_type   dn_word
);

   logic                v_ff;
   rgbbl_pkg::mul_type  word_ff;
   rgbbl_pkg::mul_type  word_in;
   logic [7:0]          inv_alpha;

   assign inv_alpha = rgbbl_pkg::ALPHA_MAX - up_word.alpha;

   // Six narrow multiplies, one per field and term
   always_comb begin
      word_in.blend = up_word.blend;
      word_in.we    = up_word.we;
      word_in.pix   = up_word.pix;
      word_in.r_src = 13'(up_word.col[15:11]) * 13'(up_word.alpha);
      word_in.g_src = 14'(up_word.col[10:5])  * 14'(up_word.alpha);
      word_in.b_src = 13'(up_word.col[4:0])   * 13'(up_word.alpha);
      word_in.r_dst = 13'(up_word.dst[15:11]) * 13'(inv_alpha);
      word_in.g_dst = 14'(up_word.dst[10:5])  * 14'(inv_alpha);
      word_in.b_dst = 13'(up_word.dst[4:0])   * 13'(inv_alpha);
   end

   assign up_ready = !v_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (up_ready) begin
         v_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         word_ff <= word_in;
      end
   end

   assign dn_valid = v_ff;
   assign dn_word  = word_ff;

endmodule

// ===== rtl/rgbbl_sum.sv =====
`timescale 1ns / 1ps
// Third pipeline stage and output register: divide by 255, add the two
// terms per field and pick blended or direct pixel. Uses rgbbl_pkg.
module rgbbl_sum (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  rgbbl_pkg::mul_type   up_word,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output logic [15:0]          new_pixel,
   output logic                 write_enable
);

   logic        v_ff;
   logic [15:0] pix_ff;
   logic        we_ff;
   logic [15:0] pix_in;
   logic [5:0]  r_sum, g_sum, b_sum;

   // Each field sum stays within its own width
   assign r_sum = rgbbl_pkg::div255({1'b0, up_word.r_src}) +
                  rgbbl_pkg::div255({1'b0, up_word.r_dst});
   assign g_sum = rgbbl_pkg::div255(up_word.g_src) + rgbbl_pkg::div255(up_word.g_dst);
   assign b_sum = rgbbl_pkg::div255({1'b0, up_word.b_src}) +
                  rgbbl_pkg::div255({1'b0, up_word.b_dst});

   assign pix_in = up_word.blend ? {r_sum[4:0], g_sum, b_sum[4:0]} : up_word.pix;

   assign up_ready = !v_ff || dn_ready;

   // Hold the result until the consumer takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (up_ready) begin
         v_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         pix_ff <= pix_in;
         we_ff  <= up_word.we;
      end
   end

   assign dn_valid     = v_ff;
   assign new_pixel    = pix_ff;
   assign write_enable = we_ff;

endmodule

// ===== rtl/rgb565_blend_blitter.sv =====
`timescale 1ns / 1ps
// Top level of the RGB565 blend blitter: control registers and the
// three-stage pipeline. Depends on rgbbl_pkg, rgbbl_decode, rgbbl_mul, rgbbl_sum.
//
//   channel  direction  word contents
//   req_     in         tdata: source_word, dest_pixel, dest_row; tuser: opcode, nibble_select
//   rsp_     out        tdata: new_pixel; tuser: write_enable
//   csr_     in         write enable, register index, write data
//
// One pixel per cycle sustained while rsp_tready stays high; an accepted pixel is
// registered in turn by the decode, multiply and divide/add stages before rsp_tvalid
// rises with its result.
// Each stage holds its own valid bit and advances when it is empty or its
// successor takes its word, so bubbles close up during output stalls.
// Synchronous reset empties the pipeline, zeroes the tint and sets
// screen_rows to 240.
module rgb565_blend_blitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // source_word[31:0], dest_pixel[47:32], dest_row[63:48]
   input  logic [3:0]  req_tuser,   // opcode[2:0], nibble_select[3]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // new_pixel[15:0]
   output logic        rsp_tuser,   // write_enable
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [rgbbl_pkg::CSR_WIDTH-1:0] csr_wdata
);

   rgbbl_pkg::cfg_type cfg_ff;
   rgbbl_pkg::dec_type dec_word;
   rgbbl_pkg::mul_type mul_word;
   logic               dec_valid, dec_ready;
   logic               mul_valid, mul_ready;

   // Control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tint_red    <= 8'd0;
         cfg_ff.tint_green  <= 8'd0;
         cfg_ff.tint_blue   <= 8'd0;
         cfg_ff.screen_rows <= rgbbl_pkg::ROWS_RESET;
      end else if (csr_we) begin
         case (rgbbl_pkg::csr_idx_type'(csr_index))
            rgbbl_pkg::CSR_TINT_RED:   cfg_ff.tint_red    <= csr_wdata[7:0];
            rgbbl_pkg::CSR_TINT_GREEN: cfg_ff.tint_green  <= csr_wdata[7:0];
            rgbbl_pkg::CSR_TINT_BLUE:  cfg_ff.tint_blue   <= csr_wdata[7:0];
            rgbbl_pkg::CSR_ROWS:       cfg_ff.screen_rows <= csr_wdata[11:0];
            default:                   cfg_ff <= cfg_ff;
         endcase
      end
   end

   rgbbl_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .up_valid      (req_tvalid),
      .up_ready      (req_tready),
      .opcode        (req_tuser[2:0]),
      .nibble_select (req_tuser[3]),
      .source_word   (req_tdata[31:0]),
      .dest_pixel    (req_tdata[47:32]),
      .dest_row      (req_tdata[63:48]),
      .cfg           (cfg_ff),
      .dn_valid      (dec_valid),
      .dn_ready      (dec_ready),
      .dn_word       (dec_word)
   );

   rgbbl_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .up_valid (dec_valid),
      .up_ready (dec_ready),
      .up_word  (dec_word),
      .dn_valid (mul_valid),
      .dn_ready (mul_ready),
      .dn_word  (mul_word)
   );

   rgbbl_sum u_sum (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (mul_valid),
      .up_ready     (mul_ready),
      .up_word      (mul_word),
      .dn_valid     (rsp_tvalid),
      .dn_ready     (rsp_tready),
      .new_pixel    (rsp_tdata),
      .write_enable (rsp_tuser)
   );

endmodule

// ===== rtl/rgbbl_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the RGB565 blend blitter, bound to the top level.
// Depends on rgbbl_pkg for the opcode values.
module rgbbl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic [3:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   logic req_acc;
   logic no_write;

   assign req_acc  = req_tvalid && req_tready;
   // Unused opcode or negative row never writes
   assign no_write = (req_tuser[2:0] > 3'(rgbbl_pkg::OP_BLEND)) || req_tdata[63];

   // Pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // With no result pending every stage has room
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output is empty");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // A pixel that is not written passes the destination through while the sink is ready
   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      req_acc && no_write ##1 rsp_tready ##1 rsp_tready
      |=> rsp_tvalid && !rsp_tuser && (rsp_tdata == $past(req_tdata[47:32], 3)))
      else $error("unwritten pixel did not pass the destination through");

endmodule

bind rgb565_blend_blitter rgbbl_checker u_rgbbl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for rgb565_blend_blitter: directed pixel table, then random pixel
// streams under several tint and row-clip settings. Depends on rgbbl_pkg and the blitter RTL.
module testbench;

   localparam int PIPE_DEPTH       = 3;
   localparam int TAIL_CYCLES      = 12;
   localparam int SINK_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int DIRECTED_ROWS    = 25;
   localparam int ALPHA_LIMIT      = int'(rgbbl_pkg::ALPHA_MAX);

   // Opcodes with no operation behind them
   localparam logic [2:0] OP_SPARE_LO  = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;

   // Red, green and blue fields of an RGB565 word
   localparam logic [2:0][15:0] FIELD_MASKS = {16'hF800, 16'h07E0, 16'h001F};

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] source_word;
      logic        nibble_select;
      logic [15:0] dest_pixel;
      logic [15:0] dest_row;
   } pixel_req_type;

   typedef struct packed {
      logic [15:0] new_pixel;
      logic        write_enable;
   } pixel_rsp_type;

   typedef struct packed {
      pixel_req_type req;
      logic          typed;
      pixel_rsp_type rsp;
   } pixel_case_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [63:0]                     req_tdata;   // source_word[31:0], dest_pixel[47:32],
                                                 // dest_row[63:48]
   logic [3:0]                      req_tuser;   // opcode[2:0], nibble_select[3]
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [15:0]                     rsp_tdata;   // new_pixel[15:0]
   logic                            rsp_tuser;   // write_enable
   logic                            csr_we;
   logic [1:0]                      csr_index;
   logic [rgbbl_pkg::CSR_WIDTH-1:0] csr_wdata;

   rgbbl_pkg::cfg_type shadow_cfg;
   pixel_rsp_type      expected_pixels[$];
   bit                 sink_hold_request;
   int                 source_calm;
   int                 mismatch_count;
   int                 pixels_sent;
   int                 results_checked;
   int                 pixels_written;
   int                 settings_written;
   int                 idle_cycles;

   rgb565_blend_blitter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Truncate 8-bit components to RGB565
   function automatic logic [15:0] to_rgb565(input logic [7:0] red, input logic [7:0] green,
                                             input logic [7:0] blue);
      return {red[7:3], green[7:2], blue[7:3]};
   endfunction

   // Mix each 565 field in place with floored alpha/255 weights
   function automatic logic [15:0] mix565(input logic [15:0] color, input logic [15:0] under,
                                          input logic [7:0] alpha);
      logic [15:0] acc;
      int          mask;
      int          fore;
      int          back;
      acc = '0;
      for (int k = 0; k < 3; k++) begin
         mask = int'(FIELD_MASKS[k]);
         fore = (((int'(color) & mask) * int'(alpha)) / ALPHA_LIMIT) & mask;
         back = (((int'(under) & mask) * (ALPHA_LIMIT - int'(alpha))) / ALPHA_LIMIT) & mask;
         acc  = acc | 16'(fore + back);
      end
      return acc;
   endfunction

   // Work out the pixel and write enable that one blit word must give
   function automatic pixel_rsp_type blit_pixel(input pixel_req_type px);
      pixel_rsp_type res;
      logic [7:0]    alpha;
      logic [15:0]   color;
      logic          visible;
      res.new_pixel    = px.dest_pixel;
      res.write_enable = 1'b0;
      visible = !px.dest_row[15] &&
                (int'(px.dest_row[14:0]) < int'(shadow_cfg.screen_rows));
      if (visible) begin
         case (px.opcode)
            rgbbl_pkg::OP_COV8, rgbbl_pkg::OP_COV4: begin
               if (px.opcode == rgbbl_pkg::OP_COV8)
                  alpha = px.source_word[7:0];
               else if (px.nibble_select)
                  alpha = {px.source_word[3:0], 4'h0};
               else
                  alpha = {px.source_word[7:4], 4'h0};
               if (alpha != 8'd0) begin
                  color = to_rgb565(shadow_cfg.tint_red, shadow_cfg.tint_green,
                                    shadow_cfg.tint_blue);
                  res.new_pixel    = mix565(color, px.dest_pixel, alpha);
                  res.write_enable = 1'b1;
               end
            end
            rgbbl_pkg::OP_COPY: begin
               res.new_pixel    = px.source_word[15:0];
               res.write_enable = 1'b1;
            end
            rgbbl_pkg::OP_KEY: begin
               color = to_rgb565(px.source_word[7:0], px.source_word[15:8],
                                 px.source_word[23:16]);
               if (color != 16'd0) begin
                  res.new_pixel    = color;
                  res.write_enable = 1'b1;
               end
            end
            rgbbl_pkg::OP_BLEND: begin
               color = to_rgb565(px.source_word[7:0], px.source_word[15:8],
                                 px.source_word[23:16]);
               res.new_pixel    = mix565(color, px.dest_pixel, px.source_word[31:24]);
               res.write_enable = 1'b1;
            end
            default: ;
         endcase
      end
      return res;
   endfunction

   // Directed pixels; typed rows carry an expected result read straight off the spec
   function automatic pixel_case_type directed_case(input int idx);
      case (idx)
         // copy at both visible row edges, then every kind of clipped row
         0:  return {rgbbl_pkg::OP_COPY, 32'hFFFF_FFFF, 1'b0, 16'h0000, 16'h0000,
                     1'b1, 16'hFFFF, 1'b1};
         1:  return {rgbbl_pkg::OP_COPY, 32'h0000_0000, 1'b0, 16'hFFFF, 16'd239,
                     1'b1, 16'h0000, 1'b1};
         2:  return {rgbbl_pkg::OP_COPY, 32'h1234_5678, 1'b0, 16'hBEEF, 16'd240,
                     1'b1, 16'hBEEF, 1'b0};
         3:  return {rgbbl_pkg::OP_COPY, 32'h1234_5678, 1'b1, 16'h0001, 16'hFFFF,
                     1'b1, 16'h0001, 1'b0};
         4:  return {rgbbl_pkg::OP_COPY, 32'hFFFF_FFFF, 1'b0, 16'h8000, 16'h8000,
                     1'b1, 16'h8000, 1'b0};
         5:  return {rgbbl_pkg::OP_COPY, 32'hFFFF_FFFF, 1'b1, 16'h7FFF, 16'h7FFF,
                     1'b1, 16'h7FFF, 1'b0};
         // coverage: zero alpha skips, full alpha over a black tint clears
         6:  return {rgbbl_pkg::OP_COV8, 32'hFFFF_FF00, 1'b0, 16'h1357, 16'd10,
                     1'b1, 16'h1357, 1'b0};
         7:  return {rgbbl_pkg::OP_COV8, 32'h0000_00FF, 1'b0, 16'hFFFF, 16'd1,
                     1'b1, 16'h0000, 1'b1};
         8:  return {rgbbl_pkg::OP_COV8, 32'h0000_0080, 1'b0, 16'hABCD, 16'd100,
                     1'b0, 17'd0};
         9:  return {rgbbl_pkg::OP_COV4, 32'h0000_000F, 1'b0, 16'h2468, 16'd3,
                     1'b1, 16'h2468, 1'b0};
         10: return {rgbbl_pkg::OP_COV4, 32'h0000_00F0, 1'b1, 16'h2468, 16'd3,
                     1'b1, 16'h2468, 1'b0};
         11: return {rgbbl_pkg::OP_COV4, 32'h0000_00F0, 1'b0, 16'h1234, 16'd50,
                     1'b0, 17'd0};
         12: return {rgbbl_pkg::OP_COV4, 32'hFFFF_FF0F, 1'b1, 16'hFFFF, 16'd239,
                     1'b0, 17'd0};
         // black key: near-black packs to zero and is skipped
         13: return {rgbbl_pkg::OP_KEY, 32'h0007_0307, 1'b0, 16'h4321, 16'd20,
                     1'b1, 16'h4321, 1'b0};
         14: return {rgbbl_pkg::OP_KEY, 32'h00FF_FFFF, 1'b0, 16'h0000, 16'd0,
                     1'b1, 16'hFFFF, 1'b1};
         15: return {rgbbl_pkg::OP_KEY, 32'hFF00_0000, 1'b1, 16'h5555, 16'd0,
                     1'b1, 16'h5555, 1'b0};
         16: return {rgbbl_pkg::OP_KEY, 32'h0012_3456, 1'b0, 16'h0000, 16'd7,
                     1'b0, 17'd0};
         // blend at both alpha extremes and in between
         17: return {rgbbl_pkg::OP_BLEND, 32'h00FF_FFFF, 1'b0, 16'h5A5A, 16'd0,
                     1'b1, 16'h5A5A, 1'b1};
         18: return {rgbbl_pkg::OP_BLEND, 32'hFFFF_FFFF, 1'b0, 16'h0000, 16'd0,
                     1'b1, 16'hFFFF, 1'b1};
         19: return {rgbbl_pkg::OP_BLEND, 32'h8040_80C0, 1'b0, 16'hF00F, 16'd120,
                     1'b0, 17'd0};
         20: return {rgbbl_pkg::OP_BLEND, 32'h0000_0000, 1'b1, 16'hFFFF, 16'd239,
                     1'b1, 16'hFFFF, 1'b1};
         // unused opcodes never write, nor does a blend on a negative row
         21: return {OP_SPARE_LO, 32'hFFFF_FFFF, 1'b0, 16'h0F0F, 16'd0,
                     1'b1, 16'h0F0F, 1'b0};
         22: return {OP_SPARE_MID, 32'h0000_0000, 1'b1, 16'h0000, 16'd1,
                     1'b1, 16'h0000, 1'b0};
         23: return {OP_SPARE_HI, 32'h00FF_FF01, 1'b0, 16'hFFFF, 16'd2,
                     1'b1, 16'hFFFF, 1'b0};
         24: return {rgbbl_pkg::OP_BLEND, 32'hFFFF_FFFF, 1'b0, 16'h1234, 16'hFFFF,
                     1'b1, 16'h1234, 1'b0};
         default: return '0;
      endcase
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Random pixel word, weighted toward alpha extremes, black keys and row edges
   function automatic pixel_req_type random_pixel();
      pixel_req_type px;
      int            roll;
      int            rows;
      rows = int'(shadow_cfg.screen_rows);
      roll = $urandom_range(99);
      if (roll < 6)
         px.opcode = 3'($urandom_range(int'(OP_SPARE_HI), int'(OP_SPARE_LO)));
      else
         px.opcode = 3'($urandom_range(int'(rgbbl_pkg::OP_BLEND), int'(rgbbl_pkg::OP_COV8)));
      px.source_word   = $urandom();
      px.nibble_select = 1'($urandom());
      px.dest_pixel    = 16'($urandom());
      roll = $urandom_range(99);
      if (roll < 8)
         px.source_word[7:0] = 8'h00;
      else if (roll < 14)
         px.source_word[7:0] = 8'hFF;
      roll = $urandom_range(99);
      if (roll < 8)
         px.source_word[31:24] = 8'h00;
      else if (roll < 14)
         px.source_word[31:24] = 8'hFF;
      if ($urandom_range(9) == 0)
         px.source_word[23:0] = {5'd0, 3'($urandom()), 6'd0, 2'($urandom()),
                                 5'd0, 3'($urandom())};
      roll = $urandom_range(99);
      if (roll < 70 && rows != 0)
         px.dest_row = 16'($urandom_range(rows - 1));
      else if (roll < 80)
         px.dest_row = {1'b1, 15'($urandom())};
      else if (roll < 90)
         px.dest_row = 16'(rows + int'($urandom_range(2)) - 1);
      else
         px.dest_row = 16'($urandom());
      return px;
   endfunction

   // Compare one result word against the oldest expected pixel
   task automatic check_result(input pixel_rsp_type got);
      pixel_rsp_type want;
      if (expected_pixels.size() == 0) begin
         $error("unexpected result word: new_pixel %h write_enable %b",
                got.new_pixel, got.write_enable);
         mismatch_count++;
         return;
      end
      want = expected_pixels.pop_front();
      results_checked++;
      if (want.write_enable)
         pixels_written++;
      if (got.new_pixel !== want.new_pixel) begin
         $error("new_pixel: expected %h, got %h", want.new_pixel, got.new_pixel);
         mismatch_count++;
      end
      if (got.write_enable !== want.write_enable) begin
         $error("write_enable: expected %b, got %b", want.write_enable, got.write_enable);
         mismatch_count++;
      end
   endtask

   // Offer one word and hold it until the blitter takes it
   task automatic offer_pixel(input pixel_req_type px, input logic typed,
                              input pixel_rsp_type known);
      req_tvalid <= 1'b1;
      req_tdata  <= {px.dest_row, px.dest_pixel, px.source_word};
      req_tuser  <= {px.nibble_select, px.opcode};
      do @(posedge clock); while (!req_tready);
      expected_pixels.push_back(typed ? known : blit_pixel(px));
      pixels_sent++;
   endtask

   // Drop valid for a random gap, or keep streaming during a calm stretch
   task automatic pause_source();
      int gap;
      if (source_calm > 0) begin
         source_calm--;
         gap = 0;
      end else if ($urandom_range(24) == 0) begin
         source_calm = $urandom_range(60, 15);
         gap = 0;
      end else begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every expected pixel has come back
   task automatic settle_pipeline();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_pixels.size() != 0);
      repeat (PIPE_DEPTH) @(posedge clock);
   endtask

   task automatic write_register(input rgbbl_pkg::csr_idx_type idx,
                                 input logic [rgbbl_pkg::CSR_WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         rgbbl_pkg::CSR_TINT_RED:   shadow_cfg.tint_red    = value[7:0];
         rgbbl_pkg::CSR_TINT_GREEN: shadow_cfg.tint_green  = value[7:0];
         rgbbl_pkg::CSR_TINT_BLUE:  shadow_cfg.tint_blue   = value[7:0];
         rgbbl_pkg::CSR_ROWS:       shadow_cfg.screen_rows = value;
         default: ;
      endcase
      settings_written++;
   endtask

   // Drain, then load all four registers
   task automatic program_settings(input logic [rgbbl_pkg::CSR_WIDTH-1:0] red,
                                   input logic [rgbbl_pkg::CSR_WIDTH-1:0] green,
                                   input logic [rgbbl_pkg::CSR_WIDTH-1:0] blue,
                                   input logic [rgbbl_pkg::CSR_WIDTH-1:0] rows);
      settle_pipeline();
      write_register(rgbbl_pkg::CSR_TINT_RED, red);
      write_register(rgbbl_pkg::CSR_TINT_GREEN, green);
      write_register(rgbbl_pkg::CSR_TINT_BLUE, blue);
      write_register(rgbbl_pkg::CSR_ROWS, rows);
      csr_we <= 1'b0;
   endtask

   // Random pixel stream; optionally stall the sink or drain mid-stream
   task automatic stream_pixels(input int count, input int hold_at, input int drain_at);
      for (int n = 0; n < count; n++) begin
         if (n == hold_at)
            sink_hold_request = 1'b1;
         offer_pixel(random_pixel(), 1'b0, '0);
         if (n == drain_at) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (expected_pixels.size() != 0);
         end else begin
            pause_source();
         end
      end
   endtask

   // Result side: check every accepted word, stall at random
   initial begin : result_sink
      int stall_left;
      int calm_left;
      stall_left = 0;
      calm_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            check_result({rsp_tdata, rsp_tuser});
         if (sink_hold_request) begin
            sink_hold_request = 1'b0;
            stall_left = SINK_HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (calm_left > 0)
               calm_left--;
            else if ($urandom_range(49) == 0)
               calm_left = $urandom_range(90, 20);
            else
               stall_left = pick_gap();
         end
      end
   end

   // Abort when no word moves on either side for too long
   initial begin : watchdog
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      pixel_case_type entry;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = rgbbl_pkg::CSR_TINT_RED;
      csr_wdata  = '0;
      sink_hold_request = 1'b0;
      source_calm      = 0;
      mismatch_count   = 0;
      pixels_sent      = 0;
      results_checked  = 0;
      pixels_written   = 0;
      settings_written = 0;
      shadow_cfg.tint_red    = 8'd0;
      shadow_cfg.tint_green  = 8'd0;
      shadow_cfg.tint_blue   = 8'd0;
      shadow_cfg.screen_rows = rgbbl_pkg::ROWS_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table under reset settings
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         entry = directed_case(i);
         offer_pixel(entry.req, entry.typed, entry.rsp);
         pause_source();
      end

      // Full tint, tallest screen; upper write bits must not reach the tint
      program_settings(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
      stream_pixels(170, -1, 90);

      // Black tint, single visible row
      program_settings(12'h000, 12'h000, 12'h000, 12'd1);
      stream_pixels(140, -1, -1);

      // Zero rows clips everything
      program_settings(12'($urandom()), 12'($urandom()), 12'($urandom()), 12'd0);
      stream_pixels(50, -1, -1);

      // Long sink stall with the source still pushing
      program_settings(12'($urandom()), 12'($urandom()), 12'($urandom()), 12'd480);
      stream_pixels(220, 40, -1);

      program_settings(12'($urandom()), 12'($urandom()), 12'($urandom()),
                       rgbbl_pkg::ROWS_RESET);
      stream_pixels(200, -1, -1);

      settle_pipeline();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("blitter run: %0d pixel words sent, %0d results checked, %0d written",
               pixels_sent, results_checked, pixels_written);
      $display("covered all opcodes, clipping, alpha extremes, %0d register writes, %0d errors",
               settings_written, mismatch_count);
      if (mismatch_count == 0 && expected_pixels.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
